// ===== hw/rtl/xcpd_pkg.sv =====
// Shared types and constants for the XOR checked packet deframer.
// Used by xcpd_front, xcpd_queue, xcpd_back and the top level; depends on nothing.
package xcpd_pkg;

  localparam logic [7:0]  HeaderReset = 8'hAA;
  localparam int unsigned BankW       = 1;
  localparam int unsigned NumBanks    = 1 << BankW;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t ptype;
    byte_t plen;
  } desc_t;

  typedef struct packed {
    logic             en;
    logic [BankW-1:0] bank;
    byte_t            idx;
    byte_t            data;
  } mem_wr_t;

endpackage

// ===== hw/rtl/xcpd_front.sv =====
// Receive side of the deframer: header hunt, type/length parse, payload write, XOR check.
// Pushes a descriptor for each good packet. Depends on xcpd_pkg.
module xcpd_front #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rx_valid_i,
  output logic                              rx_ready_o,
  input  logic [7:0]                        rx_byte_i,
  input  logic                              cfg_we_i,
  input  logic [7:0]                        cfg_wdata_i,
  input  logic                              q_full_i,
  input  logic [xcpd_pkg::BankW-1:0]        q_wr_slot_i,
  output logic                              q_push_o,
  output xcpd_pkg::desc_t                   q_desc_o,
  output xcpd_pkg::mem_wr_t                 mem_wr_o
);

  localparam int unsigned LenW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [2:0] {
    PhHunt,
    PhType,
    PhLength,
    PhPayload,
    PhCheck
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [7:0]        header_q;
  logic [7:0]        type_q, type_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   fill_q, fill_d;
  logic [7:0]        xor_q, xor_d;
  logic              accept;
  logic [LenW-1:0]   fill_inc;

  assign rx_ready_o = !q_full_i;
  assign accept     = rx_valid_i && !q_full_i;
  assign fill_inc   = LenW'(fill_q + 1'b1);

  always_comb begin
    phase_d       = phase_q;
    type_d        = type_q;
    len_d         = len_q;
    fill_d        = fill_q;
    xor_d         = xor_q;
    q_push_o      = 1'b0;
    mem_wr_o.en   = 1'b0;
    mem_wr_o.bank = q_wr_slot_i;
    mem_wr_o.idx  = 8'(fill_q);
    mem_wr_o.data = rx_byte_i;
    if (accept) begin
      unique case (phase_q)
        PhType: begin
          type_d  = rx_byte_i;
          xor_d   = rx_byte_i;
          phase_d = PhLength;
        end
        PhLength: begin
          fill_d = '0;
          if (rx_byte_i > 8'(MAX_PAYLOAD)) begin
            phase_d = PhHunt;
          end else begin
            len_d   = LenW'(rx_byte_i);
            xor_d   = xor_q ^ rx_byte_i;
            phase_d = (rx_byte_i == 8'd0) ? PhCheck : PhPayload;
          end
        end
        PhPayload: begin
          mem_wr_o.en = 1'b1;
          xor_d       = xor_q ^ rx_byte_i;
          fill_d      = fill_inc;
          if (fill_inc >= len_q) begin
            phase_d = PhCheck;
          end
        end
        PhCheck: begin
          q_push_o = (xor_q == rx_byte_i);
          phase_d  = PhHunt;
        end
        default: begin
          phase_d = (rx_byte_i == header_q) ? PhType : PhHunt;
        end
      endcase
    end
  end

  assign q_desc_o.ptype = type_q;
  assign q_desc_o.plen  = 8'(len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      header_q <= xcpd_pkg::HeaderReset;
      type_q   <= '0;
      len_q    <= '0;
      fill_q   <= '0;
      xor_q    <= '0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      fill_q  <= fill_d;
      xor_q   <= xor_d;
      if (cfg_we_i) begin
        header_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== hw/rtl/xcpd_queue.sv =====
// Two-entry descriptor queue between receive and emit sides.
// Slot numbers double as payload bank numbers. Depends on xcpd_pkg.
module xcpd_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  xcpd_pkg::desc_t             desc_i,
  output logic                        full_o,
  output logic [xcpd_pkg::BankW-1:0]  wr_slot_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output xcpd_pkg::desc_t             head_o,
  output logic [xcpd_pkg::BankW-1:0]  rd_slot_o
);

  xcpd_pkg::desc_t                 slots_q [xcpd_pkg::NumBanks];
  logic [xcpd_pkg::BankW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [xcpd_pkg::BankW:0]        count_q;

  assign full_o    = (count_q == (xcpd_pkg::BankW+1)'(xcpd_pkg::NumBanks));
  assign empty_o   = (count_q == '0);
  assign wr_slot_o = wr_ptr_q;
  assign rd_slot_o = rd_ptr_q;
  assign head_o    = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/xcpd_back.sv =====
// Emit side of the deframer: banked payload memory and the output register.
// Replays one queued packet at a time. Depends on xcpd_pkg.
module xcpd_back #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  xcpd_pkg::mem_wr_t           mem_wr_i,
  input  logic                        q_empty_i,
  input  xcpd_pkg::desc_t             q_head_i,
  input  logic [xcpd_pkg::BankW-1:0]  q_rd_slot_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  packet_type_o,
  output logic [5:0]                  packet_length_o,
  output logic                        has_data_o,
  output logic [7:0]                  data_byte_o,
  output logic [4:0]                  byte_index_o,
  output logic                        last_o
);

  localparam int unsigned LenW  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned Depth = xcpd_pkg::NumBanks << AddrW;

  logic [7:0]                        mem [Depth];
  logic [xcpd_pkg::BankW+AddrW-1:0]  rd_addr;
  logic [LenW-1:0]                   head_len;
  logic [LenW-1:0]                   emit_idx_q;
  logic                              out_valid_q;
  logic                              is_empty, is_last, load;

  assign head_len = LenW'(q_head_i.plen);
  assign is_empty = (head_len == '0);
  assign is_last  = is_empty || (LenW'(emit_idx_q + 1'b1) == head_len);
  assign load     = !q_empty_i && (!out_valid_q || out_ready_i);
  assign q_pop_o  = load && is_last;
  assign rd_addr  = {q_rd_slot_i, emit_idx_q[AddrW-1:0]};

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      mem[{mem_wr_i.bank, mem_wr_i.idx[AddrW-1:0]}] <= mem_wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      packet_type_o   <= q_head_i.ptype;
      packet_length_o <= 6'(head_len);
      has_data_o      <= !is_empty;
      data_byte_o     <= is_empty ? 8'd0 : mem[rd_addr];
      byte_index_o    <= 5'(emit_idx_q);
      last_o          <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      emit_idx_q  <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        emit_idx_q  <= is_last ? '0 : LenW'(emit_idx_q + 1'b1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/xor_checked_packet_deframer.sv =====
// Top level of the XOR checked packet deframer: receive side, descriptor queue, emit side.
// Depends on xcpd_pkg, xcpd_front, xcpd_queue and xcpd_back.
//
//   channel  handshake                 payload
//   rx       rx_valid_i / rx_ready_o   rx_byte_i
//   cfg      cfg_we_i                  cfg_wdata_i (header byte)
//   out      out_valid_o / out_ready_i packet_type_o .. last_o
//
// One received byte per cycle; rx_ready_o drops only while two checked packets wait.
// Emission: one item per cycle per payload byte (one item for an empty packet),
// paced by the single read port of the banked payload memory.
// Reset puts the parser in header hunt with header byte 0xAA; no clearing pass.
// Each side stalls on its own; a full queue stalls receive, out_ready_i stalls emit.
module xor_checked_packet_deframer #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] packet_type_o,
  output logic [5:0] packet_length_o,
  output logic       has_data_o,
  output logic [7:0] data_byte_o,
  output logic [4:0] byte_index_o,
  output logic       last_o
);

  logic                        q_push, q_full, q_pop, q_empty;
  logic [xcpd_pkg::BankW-1:0]  q_wr_slot, q_rd_slot;
  xcpd_pkg::desc_t             q_desc, q_head;
  xcpd_pkg::mem_wr_t           mem_wr;

  xcpd_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_full_i   (q_full),
    .q_wr_slot_i(q_wr_slot),
    .q_push_o   (q_push),
    .q_desc_o   (q_desc),
    .mem_wr_o   (mem_wr)
  );

  xcpd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .desc_i   (q_desc),
    .full_o   (q_full),
    .wr_slot_o(q_wr_slot),
    .pop_i    (q_pop),
    .empty_o  (q_empty),
    .head_o   (q_head),
    .rd_slot_o(q_rd_slot)
  );

  xcpd_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mem_wr_i       (mem_wr),
    .q_empty_i      (q_empty),
    .q_head_i       (q_head),
    .q_rd_slot_i    (q_rd_slot),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .packet_type_o  (packet_type_o),
    .packet_length_o(packet_length_o),
    .has_data_o     (has_data_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .last_o         (last_o)
  );

endmodule

// ===== hw/rtl/xcpd_checker.sv =====
// Port-level checks on the deframer output stream, bound to the top level.
// Depends only on the top-level ports of xor_checked_packet_deframer.
module xcpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] packet_type_o,
  input logic [5:0] packet_length_o,
  input logic       has_data_o,
  input logic [7:0] data_byte_o,
  input logic [4:0] byte_index_o,
  input logic       last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(byte_index_o) && $stable(last_o) && $stable(packet_type_o))
    else $error("output changed while stalled");

  a_empty_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |-> last_o && data_byte_o == 8'd0
      && byte_index_o == 5'd0 && packet_length_o == 6'd0)
    else $error("malformed empty-packet item");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o
      && byte_index_o == 5'($past(byte_index_o) + 5'd1)
      && packet_type_o == $past(packet_type_o))
    else $error("packet run broken after transfer");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_data_o && last_o |-> byte_index_o == 5'(packet_length_o - 6'd1))
    else $error("last item index does not match length");

endmodule

bind xor_checked_packet_deframer xcpd_checker u_xcpd_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for xor_checked_packet_deframer: framed byte streams in, packet items out.
// A scoreboard class predicts each packet item; depends on xcpd_pkg and the deframer RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPayload    = 32;
  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 10;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned PhaseBytes    = 105;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_TYPE,
    ST_LENGTH,
    ST_PAYLOAD,
    ST_CHECK
  } deframe_state_e;

  typedef enum int {
    FILL_RANDOM,
    FILL_HEADER,
    FILL_ZERO,
    FILL_ONES
  } fill_mode_e;

  typedef struct packed {
    xcpd_pkg::byte_t ptype;
    logic [5:0]      plen;
    logic            has_data;
    xcpd_pkg::byte_t data;
    logic [4:0]      idx;
    logic            last;
  } pkt_item_t;

  class packet_scoreboard;
    xcpd_pkg::byte_t header;
    deframe_state_e  state;
    xcpd_pkg::byte_t held_type;
    xcpd_pkg::byte_t xsum;
    logic [5:0]      held_len;
    int unsigned     fill;
    xcpd_pkg::byte_t payload [MaxPayload];
    pkt_item_t       pending_items [$];
    int unsigned     errors;
    int unsigned     items_checked;
    int unsigned     packets_ok;
    int unsigned     frames_dropped;

    function new();
      header    = xcpd_pkg::HeaderReset;
      state     = ST_HUNT;
      held_type = '0;
      xsum      = '0;
      held_len  = '0;
      fill      = 0;
    endfunction

    function void set_header(xcpd_pkg::byte_t value);
      header = value;
    endfunction

    function int unsigned pending();
      return pending_items.size();
    endfunction

    function void take_rx_byte(xcpd_pkg::byte_t b);
      pkt_item_t item;
      case (state)
        ST_TYPE: begin
          held_type = b;
          xsum      = b;
          state     = ST_LENGTH;
        end
        ST_LENGTH: begin
          fill = 0;
          if (b > MaxPayload) begin
            state = ST_HUNT;
            frames_dropped++;
          end else begin
            held_len = b[5:0];
            xsum     = xsum ^ b;
            state    = (b == 0) ? ST_CHECK : ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          payload[fill] = b;
          xsum          = xsum ^ b;
          fill++;
          if (fill >= held_len) state = ST_CHECK;
        end
        ST_CHECK: begin
          if (xsum == b) begin
            packets_ok++;
            item.ptype = held_type;
            item.plen  = held_len;
            if (held_len == 0) begin
              item.has_data = 1'b0;
              item.data     = '0;
              item.idx      = '0;
              item.last     = 1'b1;
              pending_items.push_back(item);
            end else begin
              for (int i = 0; i < held_len; i++) begin
                item.has_data = 1'b1;
                item.data     = payload[i];
                item.idx      = i[4:0];
                item.last     = (i + 1 == held_len);
                pending_items.push_back(item);
              end
            end
          end else begin
            frames_dropped++;
          end
          state = ST_HUNT;
        end
        default: begin
          state = (b == header) ? ST_TYPE : ST_HUNT;
        end
      endcase
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_packet_item(pkt_item_t got);
      pkt_item_t want;
      if (pending_items.size() == 0) begin
        $error("unexpected packet item: type 0x%0h length %0d index %0d",
               got.ptype, got.plen, got.idx);
        errors++;
        return;
      end
      want = pending_items.pop_front();
      items_checked++;
      compare_field("packet_type", want.ptype, got.ptype);
      compare_field("packet_length", 8'(want.plen), 8'(got.plen));
      compare_field("has_data", 8'(want.has_data), 8'(got.has_data));
      compare_field("data_byte", want.data, got.data);
      compare_field("byte_index", 8'(want.idx), 8'(got.idx));
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            rx_valid_i  = 1'b0;
  logic            rx_ready_o;
  logic [7:0]      rx_byte_i   = '0;
  logic            cfg_we_i    = 1'b0;
  logic [7:0]      cfg_wdata_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [7:0]      packet_type_o;
  logic [5:0]      packet_length_o;
  logic            has_data_o;
  logic [7:0]      data_byte_o;
  logic [4:0]      byte_index_o;
  logic            last_o;

  packet_scoreboard sb = new();
  xcpd_pkg::byte_t  cur_header       = xcpd_pkg::HeaderReset;
  int unsigned      tx_idle_pct      = 0;
  int unsigned      out_idle_pct     = 0;
  int unsigned      out_hold_cycles  = 0;
  int unsigned      quiet_cycles     = 0;
  int unsigned      frame_bytes      = 0;
  int unsigned      noise_bytes      = 0;
  int unsigned      header_settings  = 1;

  xor_checked_packet_deframer #(
    .MAX_PAYLOAD(MaxPayload)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .packet_type_o  (packet_type_o),
    .packet_length_o(packet_length_o),
    .has_data_o     (has_data_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .last_o         (last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (out_hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      out_hold_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rx_valid_i && rx_ready_o) sb.take_rx_byte(rx_byte_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_packet_item({packet_type_o, packet_length_o, has_data_o,
                            data_byte_o, byte_index_o, last_o});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("xor_checked_packet_deframer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(input xcpd_pkg::byte_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    rx_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_header(input xcpd_pkg::byte_t value);
    wait_drain();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_header = value;
    sb.set_header(value);
    header_settings++;
  endtask

  task automatic send_frame(input xcpd_pkg::byte_t ptype, input int len,
                            input fill_mode_e fill_mode, input bit bad_check,
                            input int cut_at);
    xcpd_pkg::byte_t bytes [$];
    xcpd_pkg::byte_t xsum;
    xcpd_pkg::byte_t b;
    int              n;
    bytes.push_back(cur_header);
    bytes.push_back(ptype);
    bytes.push_back(len[7:0]);
    xsum = ptype ^ len[7:0];
    if (len <= MaxPayload) begin
      for (int i = 0; i < len; i++) begin
        case (fill_mode)
          FILL_HEADER: b = cur_header;
          FILL_ZERO:   b = 8'h00;
          FILL_ONES:   b = 8'hFF;
          default:     b = 8'($urandom_range(255));
        endcase
        bytes.push_back(b);
        xsum = xsum ^ b;
      end
      if (bad_check) xsum = xsum ^ 8'($urandom_range(255, 1));
      bytes.push_back(xsum);
    end
    n = (cut_at > 0 && cut_at < bytes.size()) ? cut_at : bytes.size();
    for (int i = 0; i < n; i++) begin
      send_byte(bytes[i]);
      frame_bytes++;
    end
  endtask

  task automatic send_random_frame(input bit full_size);
    int r;
    int len;
    bit bad;
    int cut;
    r = $urandom_range(99);
    if (full_size)    len = MaxPayload;
    else if (r < 10)  len = 0;
    else if (r < 75)  len = $urandom_range(8, 1);
    else if (r < 93)  len = $urandom_range(MaxPayload, 9);
    else              len = $urandom_range(255, MaxPayload + 1);
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(3, 1)) begin
        send_byte(8'($urandom_range(255)));
        noise_bytes++;
      end
    end
    bad = !full_size && ($urandom_range(99) < 12);
    cut = (!full_size && $urandom_range(99) < 6) ? $urandom_range(len + 3, 1) : 0;
    send_frame(8'($urandom_range(255)), len, FILL_RANDOM, bad, cut);
  endtask

  task automatic run_frames(input int unsigned budget, input bit mid_pause);
    int unsigned start;
    bit          paused;
    start  = frame_bytes;
    paused = 1'b0;
    send_random_frame(1'b1);
    while (frame_bytes - start < budget) begin
      if (mid_pause && !paused && frame_bytes - start >= budget / 2) begin
        wait_drain();
        paused = 1'b1;
      end
      send_random_frame(1'b0);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct  = 27;
    out_idle_pct = 56;
    send_frame(8'h00, 0, FILL_RANDOM, 1'b0, 0);
    send_frame(8'hFF, 0, FILL_RANDOM, 1'b1, 0);
    send_frame(8'h5A, MaxPayload + 1, FILL_RANDOM, 1'b0, 0);
    send_frame(8'h3C, 255, FILL_RANDOM, 1'b0, 0);
    send_frame(cur_header, 2, FILL_HEADER, 1'b0, 0);
    send_frame(8'h81, 1, FILL_ZERO, 1'b1, 0);
    send_frame(8'h7E, 1, FILL_ONES, 1'b0, 0);
    run_frames(PhaseBytes - 30, 1'b0);

    write_header(8'h00);
    tx_idle_pct  = 56;
    out_idle_pct = 27;
    run_frames(PhaseBytes, 1'b0);

    write_header(8'hFF);
    tx_idle_pct     = 0;
    out_idle_pct    = 0;
    out_hold_cycles = LongHold;
    run_frames(PhaseBytes, 1'b0);

    write_header(8'($urandom_range(254, 1)));
    run_frames(PhaseBytes, 1'b1);

    wait_drain();
    repeat (2 * SettleCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d packet items never arrived", sb.pending());
      sb.errors++;
    end
    $display("Sent %0d framed bytes and %0d noise bytes under %0d header values.",
             frame_bytes, noise_bytes, header_settings);
    $display("Checked %0d packet items from %0d good packets; %0d frames dropped.",
             sb.items_checked, sb.packets_ok, sb.frames_dropped);
    if (sb.errors == 0) begin
      $display("xor_checked_packet_deframer test passed");
    end else begin
      $display("xor_checked_packet_deframer test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/xcpd_pkg.sv
hw/rtl/xcpd_front.sv
hw/rtl/xcpd_queue.sv
hw/rtl/xcpd_back.sv
hw/rtl/xor_checked_packet_deframer.sv
hw/rtl/xcpd_checker.sv
tb/sv/tb.sv
